// ===== hw/rtl/unique_value_set_table_assert.svh =====
// Assertion macros for the unique value set table.
`ifndef UNIQUE_VALUE_SET_TABLE_ASSERT_SVH
`define UNIQUE_VALUE_SET_TABLE_ASSERT_SVH

// Plain invariant, sampled on clk, off while rst_n is low.
`define UVST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UVST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/uvst_pkg.sv =====
// Shared types and constants for the unique value set table.
package uvst_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int CFG_W = 7;
    localparam int CNT_OUT_W = 7;
    localparam logic [CFG_W-1:0] CAP_LIMIT_RESET = 7'd64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic                 was_present;
        logic                 changed;
        logic                 full_refused;
        logic [CNT_OUT_W-1:0] entry_count;
    } rsp_item_t;

    // Request held for the length of one walk down the row.
    typedef struct packed {
        logic        is_ins;
        logic        is_del;
        logic        cap_ok;
        logic [31:0] value;
    } req_t;

    // Token and match flag handed from one cell to the next.
    typedef struct packed {
        logic tok;
        logic found;
    } link_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } state_t;

endpackage

// ===== hw/rtl/uvst_cell.sv =====
// One storage cell of the set: holds an entry, compares and shifts as the token passes.
module uvst_cell
    import uvst_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  req_t          req,
    input  logic [CW-1:0] count,
    input  link_t         link_in,
    input  logic [31:0]   nb_entry,
    output link_t         link_out,
    output logic [31:0]   entry
);

    logic [31:0] entry_reg;
    logic [31:0] entry_next;
    link_t       link_reg;
    link_t       link_next;
    logic        occupied;
    logic        hit;
    logic        found_here;

    assign occupied   = CW'(IDX) < count;
    assign hit        = occupied && (entry_reg == req.value);
    assign found_here = link_in.found | hit;

    always_comb
    begin
        entry_next = entry_reg;
        if (link_in.tok)
        begin
            // pull the upper neighbor down once the match lies at or below us
            if (req.is_del && occupied && found_here)
            begin
                entry_next = nb_entry;
            end
            else if (req.is_ins && (CW'(IDX) == count) && !link_in.found && req.cap_ok)
            begin
                entry_next = req.value;
            end
        end
    end

    always_comb
    begin
        link_next.tok   = link_in.tok;
        link_next.found = link_in.tok ? found_here : 1'b0;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;
    assign entry    = entry_reg;

endmodule

// ===== hw/rtl/unique_value_set_table.sv =====
// Top level of the unique value set table: request control, row of cells, result register.
// One command at a time: cmd_ready is high only in ST_IDLE; the token walks every cell of the row.
// A waiting response keeps the next result in ST_HOLD and so blocks the next command.
// Reset: asynchronous, active low; clears the count and sets the capacity limit to 64.
// Entries need no clearing; cells at or above the count are never compared.
`include "unique_value_set_table_assert.svh"

module unique_value_set_table
    import uvst_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_item_t        cmd,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_item_t        rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > CFG_W) ? CW : CFG_W;

    state_t            state_reg;
    state_t            state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CFG_W-1:0]  cap_limit_reg;
    req_t              req_reg;
    req_t              req_next;
    logic              start_reg;
    rsp_item_t         res_reg;
    rsp_item_t         res_next;
    logic              rsp_valid_reg;
    rsp_item_t         rsp_reg;

    logic              cmd_fire;
    logic              walk_end;
    logic              rsp_load;
    logic              cap_ok;

    link_t             link_vec  [CAPACITY+1];
    logic [31:0]       entry_vec [CAPACITY];
    logic [CAPACITY-1:0] tok_vec;

    // Row of cells

    assign link_vec[0] = '{tok: start_reg, found: 1'b0};

    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        logic [31:0] nb;
        if (gi == CAPACITY - 1)
        begin : g_last
            assign nb = entry_vec[gi];
        end
        else
        begin : g_mid
            assign nb = entry_vec[gi+1];
        end

        uvst_cell #(
            .IDX (gi),
            .CW  (CW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .req      (req_reg),
            .count    (count_reg),
            .link_in  (link_vec[gi]),
            .nb_entry (nb),
            .link_out (link_vec[gi+1]),
            .entry    (entry_vec[gi])
        );

        assign tok_vec[gi] = link_vec[gi+1].tok;
    end

    // Control

    assign cmd_fire = cmd_valid && cmd_ready;
    assign walk_end = (state_reg == ST_WALK) && link_vec[CAPACITY].tok;
    assign cfg_ready = 1'b1;

    assign cap_ok = (MW'(count_reg) < MW'(cap_limit_reg)) && (count_reg < CW'(CAPACITY));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready = 1'b0;
        rsp_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            ST_HOLD:
            begin
                rsp_load = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                cmd_ready = 1'b0;
                rsp_load  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        req_next.is_ins = (cmd.opcode == OP_INSERT);
        req_next.is_del = (cmd.opcode == OP_DELETE);
        req_next.cap_ok = cap_ok;
        req_next.value  = cmd.value;
    end

    always_comb
    begin
        count_next = count_reg;
        if (req_reg.is_ins && !link_vec[CAPACITY].found && req_reg.cap_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (req_reg.is_del && link_vec[CAPACITY].found)
        begin
            count_next = count_reg - CW'(1);
        end
        res_next.was_present  = link_vec[CAPACITY].found;
        res_next.changed      = count_next != count_reg;
        res_next.full_refused = req_reg.is_ins && !link_vec[CAPACITY].found && !req_reg.cap_ok;
        res_next.entry_count  = CNT_OUT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_limit_reg <= CAP_LIMIT_RESET;
            start_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= cmd_fire;
            if (cfg_valid && cfg_ready)
            begin
                cap_limit_reg <= cfg_data;
            end
            if (walk_end)
            begin
                count_reg <= count_next;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold the request and results
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            req_reg <= req_next;
        end
        if (walk_end)
        begin
            res_reg <= res_next;
        end
        if (rsp_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks

    `UVST_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY), "count exceeds capacity")
    `UVST_ASSERT(a_one_token, $onehot0(tok_vec), "more than one token in the row")
    `UVST_ASSERT_IMP(a_count_at_end, count_reg != $past(count_reg), $past(walk_end),
        "count changed outside the end of a walk")
    `UVST_ASSERT_IMP(a_idle_no_token, state_reg == ST_IDLE, tok_vec == '0,
        "token in the row while idle")

endmodule

// ===== tb/unique_value_set_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the unique value set table: predicts each response and compares it.
module unique_value_set_table_checker
    import uvst_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  logic             cmd_ready,
    input  cmd_item_t        cmd,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  rsp_item_t        rsp,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    output int               fail_count,
    output int               outstanding
);

    logic [31:0]      held [CAPACITY];
    int               held_count;
    logic [CFG_W-1:0] cap_limit;
    rsp_item_t        pending_rsp[$];
    rsp_item_t        want;
    int               errors;

    // Apply one set operation to the held values and return its response.
    function automatic rsp_item_t apply_set_op(cmd_item_t c);
        rsp_item_t r;
        int        hit_at;
        int        room;
        hit_at = -1;
        for (int i = 0; i < held_count; i++)
        begin
            if (hit_at < 0 && held[i] == c.value)
                hit_at = i;
        end
        room = (cap_limit < CAPACITY) ? int'(cap_limit) : CAPACITY;
        r = '0;
        r.was_present = (hit_at >= 0);
        if (c.opcode == OP_INSERT && hit_at < 0)
        begin
            if (held_count < room)
            begin
                held[held_count] = c.value;
                held_count++;
                r.changed = 1'b1;
            end
            else
                r.full_refused = 1'b1;
        end
        else if (c.opcode == OP_DELETE && hit_at >= 0)
        begin
            // close the gap, keeping insertion order
            for (int i = hit_at; i < held_count - 1; i++)
                held[i] = held[i + 1];
            held_count--;
            r.changed = 1'b1;
        end
        r.entry_count = held_count[CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic check_field(string tag, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            cap_limit = CAP_LIMIT_RESET;
            pending_rsp.delete();
            errors = 0;
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_limit = cfg_data;
            if (rsp_valid && rsp_ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response, expected none, actual %p", $time, rsp);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    check_field("was_present", want.was_present, rsp.was_present);
                    check_field("changed", want.changed, rsp.changed);
                    check_field("full_refused", want.full_refused, rsp.full_refused);
                    check_field("entry_count", want.entry_count, rsp.entry_count);
                end
            end
            if (cmd_valid && cmd_ready)
                pending_rsp.push_back(apply_set_op(cmd));
            fail_count <= errors;
            outstanding <= pending_rsp.size();
        end
    end

endmodule

// ===== tb/unique_value_set_table_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the unique value set table: stimulus, watchdog and verdict.
module unique_value_set_table_tb;
    import uvst_pkg::*;

    localparam int CAPACITY = DEFAULT_CAPACITY;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = CAPACITY + 12;
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 150;
    localparam int POOL_SIZE = 128;
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             cmd_valid;
    logic             cmd_ready;
    cmd_item_t        cmd;
    logic             rsp_valid;
    logic             rsp_ready;
    rsp_item_t        rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    int          fail_count;
    int          outstanding;
    int          stall_cycles;
    bit          steady;
    int          pool_span;
    logic [31:0] value_pool [POOL_SIZE];

    unique_value_set_table #(.CAPACITY(CAPACITY)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    unique_value_set_table_checker #(.CAPACITY(CAPACITY)) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Response side: random back-pressure per item, none while steady is set.
    initial
    begin : rsp_drive
        int gap;
        rsp_ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 7);
            if (gap != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!(rsp_valid && rsp_ready));
        end
    end

    task automatic send_set_op(logic [1:0] op, logic [31:0] v);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd.opcode <= op;
        cmd.value <= v;
        do @(posedge clk); while (!(cmd_valid && cmd_ready));
    endtask

    // Hold the sender until every outstanding response has come back.
    task automatic wait_for_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_capacity(logic [CFG_W-1:0] lim);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data <= lim;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [1:0] pick_op(int insert_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            return OP_INSERT;
        r = $urandom_range(0, 9);
        if (r < 6)
            return OP_DELETE;
        else if (r < 9)
            return OP_LOOKUP;
        return OP_SPARE;
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 99) < 85)
            return value_pool[$urandom_range(0, pool_span - 1)];
        return $urandom;
    endfunction

    initial
    begin : stimulus
        logic [CFG_W-1:0] cap_plan [PHASES];
        int               span_plan [PHASES];
        int               insert_plan [PHASES];

        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        cmd <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        steady = 1'b0;
        pool_span = 1;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        value_pool[4] = 32'h5555_5555;
        value_pool[5] = 32'haaaa_aaaa;
        for (int i = 6; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        cap_plan    = '{7'd64, 7'd1, 7'd127, 7'd0, 7'($urandom_range(2, 63)),
                        7'd100, 7'd3, 7'($urandom_range(1, 127)), 7'd64};
        span_plan   = '{12, 6, 120, 20, 30, 90, 8, 40, 64};
        insert_plan = '{45, 50, 90, 40, 50, 75, 45, 50, 60};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: empty set, extremes, every operation, capacity corners.
        set_capacity(7'd64);
        send_set_op(OP_LOOKUP, 32'h0000_0000);
        send_set_op(OP_DELETE, 32'h0000_0005);
        send_set_op(OP_INSERT, 32'h8000_0000);
        send_set_op(OP_INSERT, 32'h7fff_ffff);
        send_set_op(OP_INSERT, 32'h0000_0000);
        send_set_op(OP_INSERT, 32'hffff_ffff);
        send_set_op(OP_INSERT, 32'h0000_0001);
        send_set_op(OP_INSERT, 32'h7fff_ffff);
        send_set_op(OP_LOOKUP, 32'h8000_0000);
        send_set_op(OP_SPARE, 32'h0000_0000);
        send_set_op(OP_SPARE, 32'h5555_5555);
        send_set_op(OP_DELETE, 32'h0000_0000);
        send_set_op(OP_LOOKUP, 32'hffff_ffff);
        send_set_op(OP_DELETE, 32'h8000_0000);
        send_set_op(OP_DELETE, 32'h0000_0001);
        send_set_op(OP_DELETE, 32'h1234_5678);
        send_set_op(OP_INSERT, 32'h5555_5555);
        send_set_op(OP_INSERT, 32'haaaa_aaaa);
        // limit below the count: inserts refused, deletes still work
        set_capacity(7'd2);
        send_set_op(OP_INSERT, 32'h0000_002a);
        send_set_op(OP_LOOKUP, 32'haaaa_aaaa);
        send_set_op(OP_DELETE, 32'h7fff_ffff);
        send_set_op(OP_INSERT, 32'h0000_002a);
        set_capacity(7'd0);
        send_set_op(OP_INSERT, 32'h8000_0000);
        send_set_op(OP_INSERT, 32'hffff_ffff);

        // Random part: each phase has its own limit, value spread and idling mode.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_capacity(cap_plan[ph]);
            steady = (ph % 3 == 1);
            pool_span = span_plan[ph];
            repeat (PHASE_ITEMS)
                send_set_op(pick_op(insert_plan[ph]), pick_value());
        end

        steady = 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
